FILE: rtl/blsup_pkg.sv
// Battery level supervisor: shared types and constants.
// Used by every module of the block; depends on nothing.
package blsup_pkg;

    // Level codes
    localparam logic [1:0] LV_OK   = 2'd0;
    localparam logic [1:0] LV_LOW  = 2'd1;
    localparam logic [1:0] LV_CRIT = 2'd2;
    localparam logic [1:0] LV_SHDN = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LOW_ENTER  = 3'd0;
    localparam logic [2:0] REG_LOW_EXIT   = 3'd1;
    localparam logic [2:0] REG_CRIT_ENTER = 3'd2;
    localparam logic [2:0] REG_CRIT_EXIT  = 3'd3;
    localparam logic [2:0] REG_SHDN       = 3'd4;
    localparam logic [2:0] REG_CONFIRM    = 3'd5;
    localparam logic [2:0] REG_DWELL      = 3'd6;
    localparam logic [2:0] REG_LOW_CAP    = 3'd7;

    localparam logic [6:0] CAP_FULL = 7'd100;

    localparam int IN_W  = 48;
    localparam int OUT_W = 16;

    typedef struct packed {
        logic [15:0] low_enter_mv;
        logic [15:0] low_exit_mv;
        logic [15:0] critical_enter_mv;
        logic [15:0] critical_exit_mv;
        logic [15:0] shutdown_mv;
        logic [31:0] shdn_hold_ms;
        logic [31:0] min_dwell_ms;
        logic [6:0]  low_cap_pct;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] below_start_ms;
        logic        below_valid;
        logic [31:0] last_change_ms;
        logic        low_done;
        logic        critical_done;
        logic        latch_bit;
    } state_t;

    typedef struct packed {
        logic [1:0] level;
        logic       cap_write;
        logic [6:0] cap_pct;
        logic       low_actions_pulse;
        logic       critical_actions_pulse;
        logic       sleep_request;
        logic       power_latch;
        logic       storage_allowed;
        logic       sample_ignored;
    } result_t;

    // Brightness caps above 100 percent are clamped
    function automatic logic [6:0] cap_sat(input logic [6:0] v);
        cap_sat = (v > CAP_FULL) ? CAP_FULL : v;
    endfunction

endpackage

FILE: rtl/battery_level_supervisor_core.sv
// Battery level supervisor top level: input register, step logic, result register.
// Depends on blsup_pkg, blsup_cfg and blsup_step.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------
//  s_axis   | in  | one voltage sample with timestamp
//  m_axis   | out | one status/action result per sample
//  apb      | in  | threshold and timer registers, 4-byte stride
//
// One sample per cycle sustained while m_axis_tready is high; each sample passes the input
// register, then the result register, before its result is offered on m_axis.
// The supervisor state is updated as a sample moves into the result register,
// so results leave in sample order.
// A stalled m_axis holds the result; s_axis_tready drops once the input register is full and the result is stalled.
// rst_n clears the supervisor state and both valid flags, and loads the configuration defaults.
module battery_level_supervisor_core #(
    parameter int CRITICAL_CAP_PCT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: [15:0] vbat_mv, [47:16] timestamp_ms
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // m_axis_tdata: [1:0] level, [2] cap_write, [9:3] cap_pct,
    //   [10] low_actions_pulse, [11] critical_actions_pulse, [12] sleep_request,
    //   [13] power_latch, [14] storage_allowed, [15] sample_ignored
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int         CAP_MOD  = CRITICAL_CAP_PCT % 128;
    localparam logic [6:0] CRIT_CAP = (CAP_MOD > 100) ? 7'd100 : 7'(CAP_MOD);

    blsup_pkg::cfg_t    cfg;
    blsup_pkg::state_t  st_reg;
    blsup_pkg::state_t  st_next;
    blsup_pkg::result_t res_next;
    blsup_pkg::result_t res_reg;

    logic               in_valid_reg;
    logic [15:0]        vbat_reg;
    logic [31:0]        ts_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    assign pready = 1'b1;

    blsup_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    blsup_step #(
        .CRIT_CAP (CRIT_CAP)
    ) u_step (
        .cfg          (cfg),
        .cur          (st_reg),
        .vbat_mv      (vbat_reg),
        .timestamp_ms (ts_reg),
        .nxt          (st_next),
        .res          (res_next)
    );

    // Pipeline flow control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            vbat_reg <= s_axis_tdata[15:0];
            ts_reg   <= s_axis_tdata[47:16];
        end
    end

    // Supervisor state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {res_reg.sample_ignored, res_reg.storage_allowed,
                            res_reg.power_latch, res_reg.sleep_request,
                            res_reg.critical_actions_pulse, res_reg.low_actions_pulse,
                            res_reg.cap_pct, res_reg.cap_write, res_reg.level};

    // Shutting down is terminal until reset
    a_shdn_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.mode == blsup_pkg::LV_SHDN |=> st_reg.mode == blsup_pkg::LV_SHDN)
        else $error("left shutting-down level");

    // A sleep request only comes with the shutting-down level
    a_sleep_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.sleep_request |-> res_reg.level == blsup_pkg::LV_SHDN)
        else $error("sleep request outside shutdown");

    // Low and critical action pulses never share a beat
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.low_actions_pulse && res_reg.critical_actions_pulse))
        else $error("low and critical pulses together");

    // No cap value without a cap write, and no cap above full scale
    a_cap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.cap_write || res_reg.cap_pct == 7'd0) &&
                          res_reg.cap_pct <= blsup_pkg::CAP_FULL)
        else $error("bad cap value");

endmodule

FILE: rtl/blsup_cfg.sv
// Battery level supervisor: APB register file for thresholds and timers.
// Depends on blsup_pkg.
module blsup_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output blsup_pkg::cfg_t     cfg
);

    blsup_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [2:0]      idx;

    assign idx   = paddr[4:2];
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    // Register writes on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_enter_mv        <= 16'd3650;
            cfg_reg.low_exit_mv         <= 16'd3750;
            cfg_reg.critical_enter_mv   <= 16'd3500;
            cfg_reg.critical_exit_mv    <= 16'd3600;
            cfg_reg.shutdown_mv         <= 16'd3350;
            cfg_reg.shdn_hold_ms        <= 32'd8000;
            cfg_reg.min_dwell_ms        <= 32'd2000;
            cfg_reg.low_cap_pct         <= 7'd35;
        end
        else if (wr_en)
        begin
            case (idx)
                blsup_pkg::REG_LOW_ENTER:  cfg_reg.low_enter_mv        <= pwdata[15:0];
                blsup_pkg::REG_LOW_EXIT:   cfg_reg.low_exit_mv         <= pwdata[15:0];
                blsup_pkg::REG_CRIT_ENTER: cfg_reg.critical_enter_mv   <= pwdata[15:0];
                blsup_pkg::REG_CRIT_EXIT:  cfg_reg.critical_exit_mv    <= pwdata[15:0];
                blsup_pkg::REG_SHDN:       cfg_reg.shutdown_mv         <= pwdata[15:0];
                blsup_pkg::REG_CONFIRM:    cfg_reg.shdn_hold_ms        <= pwdata;
                blsup_pkg::REG_DWELL:      cfg_reg.min_dwell_ms        <= pwdata;
                blsup_pkg::REG_LOW_CAP:    cfg_reg.low_cap_pct         <= pwdata[6:0];
                default:                   cfg_reg.low_cap_pct         <= cfg_reg.low_cap_pct;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            blsup_pkg::REG_LOW_ENTER:  prdata = {16'd0, cfg_reg.low_enter_mv};
            blsup_pkg::REG_LOW_EXIT:   prdata = {16'd0, cfg_reg.low_exit_mv};
            blsup_pkg::REG_CRIT_ENTER: prdata = {16'd0, cfg_reg.critical_enter_mv};
            blsup_pkg::REG_CRIT_EXIT:  prdata = {16'd0, cfg_reg.critical_exit_mv};
            blsup_pkg::REG_SHDN:       prdata = {16'd0, cfg_reg.shutdown_mv};
            blsup_pkg::REG_CONFIRM:    prdata = cfg_reg.shdn_hold_ms;
            blsup_pkg::REG_DWELL:      prdata = cfg_reg.min_dwell_ms;
            blsup_pkg::REG_LOW_CAP:    prdata = {25'd0, cfg_reg.low_cap_pct};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/blsup_step.sv
// Battery level supervisor: next-state and result logic for one sample.
// Pure combinational; depends on blsup_pkg.
module blsup_step #(
    parameter logic [6:0] CRIT_CAP = 7'd10
) (
    input  blsup_pkg::cfg_t     cfg,
    input  blsup_pkg::state_t   cur,
    input  logic [15:0]         vbat_mv,
    input  logic [31:0]         timestamp_ms,
    output blsup_pkg::state_t   nxt,
    output blsup_pkg::result_t  res
);

    logic        can;
    logic        below;
    logic [31:0] start_eff;
    logic [31:0] below_elapsed;
    logic        shdn_hit;
    logic        go_crit;
    logic        cap_w;
    logic [6:0]  cap;
    logic        lowp;
    logic        critp;
    logic        sleep;

    // Dwell and below-shutdown timing, all modulo 2^32
    assign can           = (timestamp_ms - cur.last_change_ms) > cfg.min_dwell_ms;
    assign below         = vbat_mv <= cfg.shutdown_mv;
    assign start_eff     = cur.below_valid ? cur.below_start_ms : timestamp_ms;
    assign below_elapsed = timestamp_ms - start_eff;
    assign shdn_hit      = below && (below_elapsed >= cfg.shdn_hold_ms);

    always_comb
    begin
        nxt     = cur;
        go_crit = 1'b0;
        cap_w   = 1'b0;
        cap     = 7'd0;
        lowp    = 1'b0;
        critp   = 1'b0;
        sleep   = 1'b0;

        if (vbat_mv != 16'd0)
        begin
            nxt.below_valid    = below;
            nxt.below_start_ms = start_eff;

            case (cur.mode)
                blsup_pkg::LV_OK:
                begin
                    if (can)
                    begin
                        if (vbat_mv <= cfg.critical_enter_mv)
                        begin
                            go_crit = 1'b1;
                        end
                        else if (vbat_mv <= cfg.low_enter_mv)
                        begin
                            nxt.mode           = blsup_pkg::LV_LOW;
                            nxt.last_change_ms = timestamp_ms;
                            if (!cur.low_done)
                            begin
                                nxt.low_done = 1'b1;
                                cap_w        = 1'b1;
                                cap          = blsup_pkg::cap_sat(cfg.low_cap_pct);
                                lowp         = 1'b1;
                            end
                        end
                        else
                        begin
                            cap_w = 1'b1;
                            cap   = blsup_pkg::CAP_FULL;
                        end
                    end
                end
                blsup_pkg::LV_LOW:
                begin
                    if (can && vbat_mv >= cfg.low_exit_mv)
                    begin
                        nxt.mode           = blsup_pkg::LV_OK;
                        nxt.last_change_ms = timestamp_ms;
                        nxt.low_done       = 1'b0;
                        nxt.critical_done  = 1'b0;
                        nxt.latch_bit      = 1'b0;
                        cap_w              = 1'b1;
                        cap                = blsup_pkg::CAP_FULL;
                    end
                    else if (can && vbat_mv <= cfg.critical_enter_mv)
                    begin
                        go_crit = 1'b1;
                    end
                end
                blsup_pkg::LV_CRIT:
                begin
                    if (can && vbat_mv >= cfg.critical_exit_mv)
                    begin
                        nxt.mode           = blsup_pkg::LV_LOW;
                        nxt.last_change_ms = timestamp_ms;
                        nxt.latch_bit      = 1'b0;
                        cap_w              = 1'b1;
                        cap                = blsup_pkg::cap_sat(cfg.low_cap_pct);
                    end
                    // shutdown check runs after recovery and wins the level
                    if (shdn_hit)
                    begin
                        nxt.mode           = blsup_pkg::LV_SHDN;
                        nxt.last_change_ms = timestamp_ms;
                        sleep              = 1'b1;
                    end
                end
                default:
                begin
                    // shutting down is terminal
                    nxt.mode = cur.mode;
                end
            endcase

            // entry into critical, actions only once per recovery
            if (go_crit)
            begin
                nxt.mode           = blsup_pkg::LV_CRIT;
                nxt.last_change_ms = timestamp_ms;
                if (!cur.critical_done)
                begin
                    nxt.critical_done = 1'b1;
                    nxt.latch_bit     = 1'b1;
                    cap_w             = 1'b1;
                    cap               = CRIT_CAP;
                    critp             = 1'b1;
                end
            end
        end
    end

    // Result fields
    always_comb
    begin
        res.level                  = nxt.mode;
        res.cap_write              = cap_w;
        res.cap_pct                = cap;
        res.low_actions_pulse      = lowp;
        res.critical_actions_pulse = critp;
        res.sleep_request          = sleep;
        res.power_latch            = nxt.latch_bit;
        res.storage_allowed        = !nxt.latch_bit &&
                                     (nxt.mode == blsup_pkg::LV_OK ||
                                      nxt.mode == blsup_pkg::LV_LOW);
        res.sample_ignored         = (vbat_mv == 16'd0);
    end

endmodule
